// ===== hw/rtl/cqiu_pkg.sv =====
package cqiu_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_PEEK   = 2'd2,
      OP_CHANGE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_BADPOS   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_SEND
   } state_type;

   typedef struct packed {
      op_type             req_type;
      logic signed [31:0] data_in;
      logic [3:0]         position;
   } req_beat_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] data_out;
      logic               is_empty;
      logic               is_full;
   } rsp_beat_type;

   // One command travelling down the row of cells.
   typedef struct packed {
      logic               present;
      logic               act;
      op_type             op;
      logic signed [31:0] data;
   } tok_type;

endpackage

// ===== hw/rtl/cqiu_cell.sv =====
module cqiu_cell import cqiu_pkg::*; #(
   parameter int IDX_W = 3,
   parameter int IDX   = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  tok_type            tok_i,
   input  logic [IDX_W-1:0]   tgt_i,
   input  logic signed [31:0] nbr_i,
   output tok_type            tok_o,
   output logic [IDX_W-1:0]   tgt_o,
   output logic signed [31:0] word_o
);

   tok_type            tok_ff;
   tok_type            tok_in;
   logic [IDX_W-1:0]   tgt_ff;
   logic signed [31:0] entry_ff;
   logic signed [31:0] entry_in;
   logic               hit;

   assign hit = tok_i.act && (tgt_i == IDX_W'(IDX));

   always_comb begin
      entry_in = entry_ff;
      tok_in   = tok_i;
      case (tok_i.op)
         OP_INSERT, OP_CHANGE: begin
            if (hit) begin
               entry_in = tok_i.data;
            end
         end
         OP_DELETE: begin
            // Every cell takes its younger neighbor's word as the command passes.
            if (tok_i.act) begin
               entry_in = nbr_i;
            end
            if (hit) begin
               tok_in.data = entry_ff;
            end
         end
         OP_PEEK: begin
            if (hit) begin
               tok_in.data = entry_ff;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff   <= tgt_i;
      entry_ff <= entry_in;
   end

   assign tok_o  = tok_ff;
   assign tgt_o  = tgt_ff;
   assign word_o = entry_ff;

endmodule

// ===== hw/rtl/circular_queue_indexed_update.sv =====
// A FIFO of DEPTH signed 32-bit words that serves insert, delete-oldest, peek-newest and
// overwrite-at-position requests, each answered by exactly one result beat with a status and
// the empty and full flags after the request. The words sit in a row of DEPTH cells ordered
// from oldest to newest, and every request travels down that row one cell per cycle, so one
// request is handled at a time: it passes each cell's register, is captured at the end and is
// loaded into the result register, after which a new request can be taken. A result that is not
// taken holds back the result of the next request, though that request itself is still taken.
module circular_queue_indexed_update import cqiu_pkg::*; #(
   parameter int DEPTH = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_beat_type req_beat,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_beat_type rsp_beat
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OW = $clog2(DEPTH + 1);
   localparam int CW = (OW > 4) ? OW : 4;

   state_type          state_ff;
   state_type          state_in;
   logic [OW-1:0]      occ_ff;
   logic [OW-1:0]      occ_in;
   status_type         stat_ff;
   status_type         stat_in;
   logic               empty_ff;
   logic               full_ff;
   logic               ret_ff;
   logic               ret_in;
   logic signed [31:0] rdata_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_beat_type       rsp_beat_ff;
   rsp_beat_type       rsp_beat_in;

   logic               accept;
   logic               slot_free;
   logic               capture;
   logic               load;
   logic               act;
   logic [IW-1:0]      tgt;
   logic [OW-1:0]      occ_m1;
   logic [CW-1:0]      pos_w;
   logic [CW-1:0]      occ_w;
   logic [CW-1:0]      pos_m1;

   tok_type            tok_w  [DEPTH+1];
   logic [IW-1:0]      tgt_w  [DEPTH+1];
   logic signed [31:0] word_w [DEPTH+1];

   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign occ_m1 = occ_ff - OW'(1);
   assign pos_w  = CW'(req_beat.position);
   assign occ_w  = CW'(occ_ff);
   assign pos_m1 = pos_w - CW'(1);

   always_comb begin
      act     = 1'b0;
      ret_in  = 1'b0;
      tgt     = '0;
      occ_in  = occ_ff;
      stat_in = ST_OK;
      case (req_beat.req_type)
         OP_INSERT: begin
            if (occ_ff == OW'(DEPTH)) begin
               stat_in = ST_OVERFLOW;
            end else begin
               act    = 1'b1;
               tgt    = occ_ff[IW-1:0];
               occ_in = occ_ff + OW'(1);
            end
         end
         OP_DELETE: begin
            if (occ_ff == '0) begin
               stat_in = ST_EMPTY;
            end else begin
               act    = 1'b1;
               ret_in = 1'b1;
               occ_in = occ_m1;
            end
         end
         OP_PEEK: begin
            if (occ_ff == '0) begin
               stat_in = ST_EMPTY;
            end else begin
               act    = 1'b1;
               ret_in = 1'b1;
               tgt    = occ_m1[IW-1:0];
            end
         end
         OP_CHANGE: begin
            if ((pos_w == '0) || (pos_w > occ_w)) begin
               stat_in = ST_BADPOS;
            end else begin
               act = 1'b1;
               tgt = pos_m1[IW-1:0];
            end
         end
         default: begin
            stat_in = ST_OK;
         end
      endcase
   end

   always_comb begin
      tok_w[0]         = '0;
      tok_w[0].present = accept;
      tok_w[0].act     = accept && act;
      tok_w[0].op      = req_beat.req_type;
      tok_w[0].data    = req_beat.data_in;
      tgt_w[0]         = tgt;
   end

   assign word_w[DEPTH] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cqiu_cell #(
         .IDX_W (IW),
         .IDX   (i)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .tok_i  (tok_w[i]),
         .tgt_i  (tgt_w[i]),
         .nbr_i  (word_w[i+1]),
         .tok_o  (tok_w[i+1]),
         .tgt_o  (tgt_w[i+1]),
         .word_o (word_w[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (tok_w[DEPTH].present) begin
               state_in = S_SEND;
            end
         end
         S_SEND: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      capture   = 1'b0;
      load      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
         end
         S_WALK: begin
            capture = tok_w[DEPTH].present;
         end
         S_SEND: begin
            load = slot_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      rsp_beat_in.status   = stat_ff;
      rsp_beat_in.data_out = ret_ff ? rdata_ff : '0;
      rsp_beat_in.is_empty = empty_ff;
      rsp_beat_in.is_full  = full_ff;
      rsp_valid_in         = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            occ_ff <= occ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stat_ff  <= stat_in;
         ret_ff   <= ret_in;
         empty_ff <= (occ_in == '0);
         full_ff  <= (occ_in == OW'(DEPTH));
      end
      if (capture) begin
         rdata_ff <= tok_w[DEPTH].data;
      end
      if (load) begin
         rsp_beat_ff <= rsp_beat_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

endmodule

// ===== hw/rtl/cqiu_checker.sv =====
module cqiu_checker import cqiu_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_beat_type rsp_beat
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_beat))
      else $error("result beat changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in flight");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_beat.is_empty && rsp_beat.is_full))
      else $error("queue reported both empty and full");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_beat.status == ST_OVERFLOW) |->
         rsp_beat.is_full && (rsp_beat.data_out == '0))
      else $error("overflow reported on a queue that is not full");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_beat.status == ST_EMPTY) |->
         rsp_beat.is_empty && (rsp_beat.data_out == '0))
      else $error("empty status reported on a queue that holds entries");

endmodule

bind circular_queue_indexed_update cqiu_checker u_cqiu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_beat  (rsp_beat)
);
